FILE: hw/rtl/sbsi_pkg.sv
// ----------------------------------------------------------------------------
// sbsi_pkg
// Shared widths, types and helpers for the segment/box slab intersection unit.
// ----------------------------------------------------------------------------
package sbsi_pkg;

    localparam int unsigned QW    = 49;            // quotient magnitude bits
    localparam int unsigned DW    = 33;            // divisor magnitude bits
    localparam int unsigned ZW    = DW + QW;       // remainder and quotient word
    localparam int unsigned NCELL = QW;            // one quotient bit per cell
    localparam int unsigned TW    = 51;            // signed slab time width
    localparam int unsigned NLANE = 4;             // x lo, x hi, y lo, y hi

    localparam logic signed [TW-1:0] T_NEG_INF = -(TW'(1) <<< 50);
    localparam logic signed [TW-1:0] T_POS_INF = (TW'(1) <<< 50) - TW'(1);
    localparam logic signed [TW-1:0] T_ONE     = TW'(65536);
    localparam logic signed [TW-1:0] T_ZERO    = TW'(0);
    localparam logic signed [TW-1:0] SAT_HI    = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] SAT_LO    = -SAT_HI - TW'(1);

    typedef logic [NLANE-1:0][ZW-1:0] t_zvec;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [DW-1:0]      dmag_x;
        logic [DW-1:0]      dmag_y;
        logic [1:0]         dnz;      // bit 0 x, bit 1 y
        logic               in_slab;
        logic [NLANE-1:0]   qneg;
    } t_side;

    function automatic logic signed [31:0] sat32(input logic signed [TW-1:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sbsi_front.sv
// ----------------------------------------------------------------------------
// sbsi_front
// Input stage: displacements, slab offsets and divider operands.
// ----------------------------------------------------------------------------
module sbsi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_start_x,
    input  logic signed [31:0]   i_start_y,
    input  logic signed [31:0]   i_target_x,
    input  logic signed [31:0]   i_target_y,
    input  logic signed [31:0]   i_box_left,
    input  logic signed [31:0]   i_box_top,
    input  logic [30:0]          i_box_width,
    input  logic [30:0]          i_box_height,
    output logic                 o_valid,
    output sbsi_pkg::t_side      o_side,
    output sbsi_pkg::t_zvec      o_z
);

    logic                  r_valid;
    sbsi_pkg::t_side       r_side;
    sbsi_pkg::t_zvec       r_z;
    sbsi_pkg::t_side       n_side;
    sbsi_pkg::t_zvec       n_z;

    logic signed [32:0] dx, dy, hx, hy;
    logic signed [33:0] num [sbsi_pkg::NLANE];
    logic [32:0]        nmag [sbsi_pkg::NLANE];

    always_comb begin
        dx = 33'(i_target_x) - 33'(i_start_x);
        dy = 33'(i_target_y) - 33'(i_start_y);
        hx = 33'(i_box_left) + $signed({2'b00, i_box_width});
        hy = 33'(i_box_top) + $signed({2'b00, i_box_height});
        num[0] = 34'(i_box_left) - 34'(i_start_x);
        num[1] = 34'(hx) - 34'(i_start_x);
        num[2] = 34'(i_box_top) - 34'(i_start_y);
        num[3] = 34'(hy) - 34'(i_start_y);

        n_side.sx     = i_start_x;
        n_side.sy     = i_start_y;
        n_side.dx     = dx;
        n_side.dy     = dy;
        n_side.dmag_x = dx[32] ? 33'(-dx) : 33'(dx);
        n_side.dmag_y = dy[32] ? 33'(-dy) : 33'(dy);
        n_side.dnz    = {dy != '0, dx != '0};
        // a still axis must have the start strictly inside its slab
        n_side.in_slab = ((dx != '0) || ((33'(i_start_x) > 33'(i_box_left)) &&
                                          (33'(i_start_x) < hx))) &&
                         ((dy != '0) || ((33'(i_start_y) > 33'(i_box_top)) &&
                                          (33'(i_start_y) < hy)));
        for (int l = 0; l < sbsi_pkg::NLANE; l++) begin
            nmag[l] = num[l][33] ? 33'(-num[l]) : 33'(num[l]);
            n_z[l]  = {sbsi_pkg::DW'(0), nmag[l], 16'h0000};
            n_side.qneg[l] = num[l][33] ^ ((l < 2) ? dx[32] : dy[32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= n_side;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_z     = r_z;

endmodule

FILE: hw/rtl/sbsi_cell.sv
// ----------------------------------------------------------------------------
// sbsi_cell
// One restoring division step for all four slab times of a word.
// ----------------------------------------------------------------------------
module sbsi_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  sbsi_pkg::t_side  i_side,
    input  sbsi_pkg::t_zvec  i_z,
    output logic             o_valid,
    output sbsi_pkg::t_side  o_side,
    output sbsi_pkg::t_zvec  o_z
);

    logic             r_valid;
    sbsi_pkg::t_side  r_side;
    sbsi_pkg::t_zvec  r_z;
    sbsi_pkg::t_zvec  n_z;

    logic [sbsi_pkg::ZW:0]   sh  [sbsi_pkg::NLANE];
    logic [sbsi_pkg::DW:0]   up  [sbsi_pkg::NLANE];
    logic [sbsi_pkg::DW:0]   dv  [sbsi_pkg::NLANE];
    logic [sbsi_pkg::DW:0]   dif [sbsi_pkg::NLANE];
    logic                    qb  [sbsi_pkg::NLANE];

    always_comb begin
        for (int l = 0; l < sbsi_pkg::NLANE; l++) begin
            sh[l]  = {i_z[l], 1'b0};
            up[l]  = sh[l][sbsi_pkg::ZW -: (sbsi_pkg::DW + 1)];
            dv[l]  = {1'b0, (l < 2) ? i_side.dmag_x : i_side.dmag_y};
            dif[l] = up[l] - dv[l];
            qb[l]  = (up[l] >= dv[l]);
            n_z[l] = {qb[l] ? dif[l][sbsi_pkg::DW-1:0] : up[l][sbsi_pkg::DW-1:0],
                      sh[l][sbsi_pkg::QW-1:1], qb[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_side <= i_side;
            r_z    <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_z     = r_z;

endmodule

FILE: hw/rtl/sbsi_back.sv
// ----------------------------------------------------------------------------
// sbsi_back
// Slab merge, hit decision, hit point and output register.
// ----------------------------------------------------------------------------
module sbsi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  sbsi_pkg::t_side    i_side,
    input  sbsi_pkg::t_zvec    i_z,
    output logic               o_valid,
    output logic               o_hit,
    output logic signed [31:0] o_entry_time,
    output logic signed [31:0] o_hit_x,
    output logic signed [31:0] o_hit_y
);

    // stage 1: times and decision
    logic                     r1_valid, r1_hit;
    logic signed [31:0]       r1_t, r1_sx, r1_sy;
    logic signed [32:0]       r1_dx, r1_dy;
    // stage 2: products
    logic                     r2_valid, r2_hit;
    logic signed [31:0]       r2_t, r2_sx, r2_sy;
    logic signed [64:0]       r2_px, r2_py;
    // stage 3: output word
    logic                     r3_valid, r3_hit;
    logic signed [31:0]       r3_t, r3_hx, r3_hy;

    logic signed [sbsi_pkg::TW-1:0] q [sbsi_pkg::NLANE];
    logic signed [sbsi_pkg::TW-1:0] ax, bx, ay, by, ent, ext;
    logic                           n_hit;
    logic signed [64:0]             n_px, n_py, adj_x, adj_y;
    logic signed [49:0]             sum_x, sum_y;

    always_comb begin
        for (int l = 0; l < sbsi_pkg::NLANE; l++) begin
            q[l] = i_side.qneg[l]
                 ? -$signed({2'b00, i_z[l][sbsi_pkg::QW-1:0]})
                 :  $signed({2'b00, i_z[l][sbsi_pkg::QW-1:0]});
        end
        ax  = (q[0] < q[1]) ? q[0] : q[1];
        bx  = (q[0] < q[1]) ? q[1] : q[0];
        ay  = (q[2] < q[3]) ? q[2] : q[3];
        by  = (q[2] < q[3]) ? q[3] : q[2];
        ent = i_side.dnz[0] ? ax : sbsi_pkg::T_NEG_INF;
        ext = i_side.dnz[0] ? bx : sbsi_pkg::T_POS_INF;
        if (i_side.dnz[1] && (ay > ent)) begin
            ent = ay;
        end
        if (i_side.dnz[1] && (by < ext)) begin
            ext = by;
        end
        n_hit = i_side.in_slab && (ext > ent) && (ext > sbsi_pkg::T_ZERO) &&
                (ent < sbsi_pkg::T_ONE);

        n_px  = 65'(r1_dx) * 65'(r1_t);
        n_py  = 65'(r1_dy) * 65'(r1_t);

        // truncate toward zero on the divide by one
        adj_x = r2_px + (r2_px[64] ? 65'sd65535 : 65'sd0);
        adj_y = r2_py + (r2_py[64] ? 65'sd65535 : 65'sd0);
        sum_x = 50'(r2_sx) + 50'(adj_x >>> 16);
        sum_y = 50'(r2_sy) + 50'(adj_y >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r1_hit <= n_hit;
            r1_t   <= n_hit ? sbsi_pkg::sat32(ent) : 32'sd0;
            r1_sx  <= i_side.sx;
            r1_sy  <= i_side.sy;
            r1_dx  <= i_side.dx;
            r1_dy  <= i_side.dy;

            r2_hit <= r1_hit;
            r2_t   <= r1_t;
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_px  <= n_px;
            r2_py  <= n_py;

            r3_hit <= r2_hit;
            r3_t   <= r2_t;
            r3_hx  <= r2_hit ? sbsi_pkg::sat32(sbsi_pkg::TW'(sum_x)) : 32'sd0;
            r3_hy  <= r2_hit ? sbsi_pkg::sat32(sbsi_pkg::TW'(sum_y)) : 32'sd0;
        end
    end

    assign o_valid      = r3_valid;
    assign o_hit        = r3_hit;
    assign o_entry_time = r3_t;
    assign o_hit_x      = r3_hx;
    assign o_hit_y      = r3_hy;

endmodule

FILE: hw/rtl/segment_box_slab_intersect_2d_unit.sv
// ----------------------------------------------------------------------------
// segment_box_slab_intersect_2d_unit
// Segment vs axis-aligned box slab test, Q16.16, one query per unstalled cycle
// ----------------------------------------------------------------------------
// One word in and one word out per cycle while the output is not stalled. The
// pipeline is one input stage, a chain of 49 division cells that each settle
// one quotient bit of all four slab times, and three stages for the slab
// merge, the hit point multiply and the output register. A stall on the output
// freezes the whole pipeline, so the input is taken whenever the output word
// is empty or taken. A miss gives tuser 0 and an all-zero tdata.
// ----------------------------------------------------------------------------
module segment_box_slab_intersect_2d_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x, start_y, target_x, target_y, box_left, box_top,
    // box_width[222:192], box_height[253:223], zero pad
    input  logic [255:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_time[31:0], hit_x[63:32], hit_y[95:64]
    output logic [95:0]  m_axis_tdata,
    // is_hit
    output logic         m_axis_tuser
);

    logic                 en;
    logic                 c_valid [sbsi_pkg::NCELL+1];
    sbsi_pkg::t_side      c_side  [sbsi_pkg::NCELL+1];
    sbsi_pkg::t_zvec      c_z     [sbsi_pkg::NCELL+1];
    logic signed [31:0]   entry_time, hit_x, hit_y;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    sbsi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (s_axis_tvalid),
        .i_start_x    (s_axis_tdata[31:0]),
        .i_start_y    (s_axis_tdata[63:32]),
        .i_target_x   (s_axis_tdata[95:64]),
        .i_target_y   (s_axis_tdata[127:96]),
        .i_box_left   (s_axis_tdata[159:128]),
        .i_box_top    (s_axis_tdata[191:160]),
        .i_box_width  (s_axis_tdata[222:192]),
        .i_box_height (s_axis_tdata[253:223]),
        .o_valid      (c_valid[0]),
        .o_side       (c_side[0]),
        .o_z          (c_z[0])
    );

    for (genvar k = 0; k < sbsi_pkg::NCELL; k++) begin : g_cell
        sbsi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[k]),
            .i_side  (c_side[k]),
            .i_z     (c_z[k]),
            .o_valid (c_valid[k+1]),
            .o_side  (c_side[k+1]),
            .o_z     (c_z[k+1])
        );
    end

    sbsi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (c_valid[sbsi_pkg::NCELL]),
        .i_side       (c_side[sbsi_pkg::NCELL]),
        .i_z          (c_z[sbsi_pkg::NCELL]),
        .o_valid      (m_axis_tvalid),
        .o_hit        (m_axis_tuser),
        .o_entry_time (entry_time),
        .o_hit_x      (hit_x),
        .o_hit_y      (hit_y)
    );

    assign m_axis_tdata = {hit_y, hit_x, entry_time};

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss word carries nonzero data");

    a_entry_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> ($signed(m_axis_tdata[31:0]) < 32'sd65536))
        else $error("hit entry time beyond segment end");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed under stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
